// ----- hw/rtl/tra_pkg.sv -----
// Shared types and constants of the teletext row attribute decoder.
package tra_pkg;

	// Number of display cells in one row; later cells decode as spaces.
	localparam int ROW_CELLS = 40;
	localparam int CNT_W = $clog2(ROW_CELLS + 1);
	typedef logic [CNT_W-1:0] cell_cnt_t;

	// Character codes with a fixed meaning.
	localparam logic [6:0] CODE_SPACE     = 7'h20;
	localparam logic [6:0] CODE_END_BOX   = 7'h0A;
	localparam logic [6:0] CODE_START_BOX = 7'h0B;

	// Column groups (bits 6:4 of the code).
	localparam logic [2:0] GRP_ALPHA  = 3'd0;
	localparam logic [2:0] GRP_MOSAIC = 3'd1;

	// Low nibbles of the controls in column 0.
	localparam logic [3:0] CTL_FLASH     = 4'h8;
	localparam logic [3:0] CTL_STEADY    = 4'h9;
	localparam logic [3:0] CTL_END_BOX   = 4'hA;
	localparam logic [3:0] CTL_START_BOX = 4'hB;

	// Low nibbles of the controls in column 1.
	localparam logic [3:0] CTL_CONCEAL  = 4'h8;
	localparam logic [3:0] CTL_CONTIG   = 4'h9;
	localparam logic [3:0] CTL_SEP      = 4'hA;
	localparam logic [3:0] CTL_ESC      = 4'hB;
	localparam logic [3:0] CTL_BLACK_BG = 4'hC;
	localparam logic [3:0] CTL_NEW_BG   = 4'hD;
	localparam logic [3:0] CTL_HOLD     = 4'hE;
	localparam logic [3:0] CTL_RELEASE  = 4'hF;

	// Configuration register indexes.
	localparam logic [1:0] REG_DEFAULT_SET   = 2'd0;
	localparam logic [1:0] REG_HAS_SECOND    = 2'd1;
	localparam logic [1:0] REG_SECOND_SET    = 2'd2;
	localparam logic [1:0] REG_SECOND_SUBSET = 2'd3;

	typedef struct packed {
		logic [3:0] default_set;
		logic       has_second;
		logic [3:0] second_set;
		logic [2:0] second_subset;
	} cfg_regs_t;

	localparam cfg_regs_t CFG_RESET = '{
		default_set: 4'd0, has_second: 1'b0, second_set: 4'd0, second_subset: 3'd0
	};

	// Spacing-attribute state carried from cell to cell along a row.
	typedef struct packed {
		logic [2:0] fg;
		logic [2:0] bg;
		logic       mosaic;
		logic       separated;
		logic       flash;
		logic       conceal;
		logic       box;
		logic       tall;
		logic       escape;
		logic [6:0] held;
		logic [6:0] last_code;
		logic       last_valid;
	} row_state_t;

	localparam row_state_t ROW_RESET = '{
		fg: 3'd7, bg: 3'd0, mosaic: 1'b0, separated: 1'b0, flash: 1'b0,
		conceal: 1'b0, box: 1'b0, tall: 1'b0, escape: 1'b0,
		held: CODE_SPACE, last_code: 7'd0, last_valid: 1'b0
	};

	// Decoded cell.
	typedef struct packed {
		logic [6:0] character;
		logic [2:0] foreground;
		logic [2:0] background;
		logic       mosaic;
		logic       separated;
		logic       flashing;
		logic       concealed;
		logic       in_box;
		logic       tall;
		logic       held_mark;
		logic [3:0] char_set;
		logic [2:0] option_subset;
	} cell_res_t;

endpackage

// ----- hw/rtl/tra_if.sv -----
// Channel interfaces of the teletext row attribute decoder.
interface tra_in_if;
	logic       valid;
	logic       ready;
	logic [7:0] code_byte;
	logic       row_start;
	logic [2:0] page_option_subset;

	modport source (output valid, code_byte, row_start, page_option_subset, input ready);
	modport sink (input valid, code_byte, row_start, page_option_subset, output ready);
endinterface

interface tra_out_if;
	logic       valid;
	logic       ready;
	logic [6:0] character;
	logic [2:0] foreground;
	logic [2:0] background;
	logic       mosaic;
	logic       separated;
	logic       flashing;
	logic       concealed;
	logic       in_box;
	logic       tall;
	logic       held_mark;
	logic [3:0] char_set;
	logic [2:0] option_subset;

	modport source (
		output valid, character, foreground, background, mosaic, separated, flashing,
			concealed, in_box, tall, held_mark, char_set, option_subset,
		input ready
	);
	modport sink (
		input valid, character, foreground, background, mosaic, separated, flashing,
			concealed, in_box, tall, held_mark, char_set, option_subset,
		output ready
	);
endinterface

interface tra_cfg_if;
	logic       valid;
	logic       ready;
	logic [1:0] index;
	logic [3:0] data;

	modport source (output valid, index, data, input ready);
	modport sink (input valid, index, data, output ready);
endinterface

// ----- hw/rtl/tra_decode.sv -----
// Per-cell decode: attributes of one cell and the row state it leaves behind.
module tra_decode
	import tra_pkg::*;
(
	input  row_state_t st,
	input  logic [6:0] code,
	input  cfg_regs_t  cfg,
	input  logic [2:0] page_subset,
	output row_state_t nxt,
	output cell_res_t  res
);

	// Character set selection uses the escape state in force before this cell.
	always_comb begin
		nxt = st;
		res.character = CODE_SPACE;
		res.foreground = st.fg;
		res.background = st.bg;
		res.mosaic = st.mosaic;
		res.separated = st.separated;
		res.flashing = st.flash;
		res.concealed = st.conceal;
		res.in_box = st.box;
		res.tall = 1'b0;
		res.held_mark = 1'b0;
		if (st.escape && cfg.has_second) begin
			res.char_set = cfg.second_set;
			res.option_subset = cfg.second_subset;
		end else begin
			res.char_set = cfg.default_set;
			res.option_subset = page_subset;
		end

		case (code[6:4])
			GRP_ALPHA: begin
				// Alpha colours and controls act after the cell; steady and height also on it.
				if (!code[3]) begin
					nxt.fg = code[2:0];
					nxt.mosaic = 1'b0;
					nxt.conceal = 1'b0;
					nxt.held = CODE_SPACE;
				end else begin
					case (code[3:0])
						CTL_FLASH: nxt.flash = 1'b1;
						CTL_STEADY: begin
							nxt.flash = 1'b0;
							res.flashing = 1'b0;
						end
						CTL_END_BOX: begin
							if (st.last_valid && st.last_code == CODE_END_BOX) nxt.box = 1'b0;
						end
						CTL_START_BOX: begin
							if (st.last_valid && st.last_code == CODE_START_BOX) nxt.box = 1'b1;
						end
						default: begin
							nxt.tall = code[0];
							nxt.held = CODE_SPACE;
						end
					endcase
				end
				res.tall = nxt.tall;
			end
			GRP_MOSAIC: begin
				// Column 1 controls; mosaic colours show on the control cell.
				case (code[3:0])
					CTL_CONCEAL: begin
						nxt.conceal = 1'b1;
						res.concealed = 1'b1;
					end
					CTL_CONTIG: begin
						nxt.separated = 1'b0;
						res.separated = 1'b0;
					end
					CTL_SEP: begin
						nxt.separated = 1'b1;
						res.separated = 1'b1;
					end
					CTL_ESC: begin
						if (cfg.has_second) nxt.escape = !st.escape;
					end
					CTL_BLACK_BG: begin
						nxt.bg = 3'd0;
						res.background = 3'd0;
					end
					CTL_NEW_BG: begin
						nxt.bg = st.fg;
						res.background = st.fg;
					end
					CTL_HOLD: begin
						res.character = st.held;
						res.held_mark = 1'b1;
					end
					CTL_RELEASE: ;
					default: begin
						nxt.fg = code[2:0];
						nxt.mosaic = 1'b1;
						nxt.conceal = 1'b0;
					end
				endcase
				res.mosaic = nxt.mosaic;
				res.foreground = nxt.fg;
			end
			default: begin
				// Printable cell: mosaics load the held code, capitals blast through.
				res.character = code;
				if (st.mosaic && code[5]) begin
					nxt.held = code;
					res.held_mark = 1'b1;
				end else if (st.mosaic && code[6:5] == 2'b10) begin
					res.mosaic = 1'b0;
				end
			end
		endcase

		nxt.last_code = code;
		nxt.last_valid = 1'b1;
	end

endmodule

// ----- hw/rtl/teletext_row_attribute_decoder_top.sv -----
// Top level of the teletext row attribute decoder.
// The block takes one display byte per word on in_ch, with a row-start flag
// and the page's option subset, and returns one decoded cell per word on
// out_ch: character, colours, attribute flags, character set and subset.
// cfg_ch writes the four character-set registers and is always ready; the
// user must write it only while no word is in flight; the block does not enforce it.
// Each input word is registered in stage one, decoded against the row state
// in a single pass of logic and registered into the output stage when that
// stage is empty or taken. One word can be accepted in every cycle while
// out_ch does not stall; the row state and cell counter registers carry
// state from cell to cell.
// When out_ch stalls, the output word holds, stage one fills, and then
// in_ch.ready drops until the receiver takes the held word.
// Reset clears both stages, the row state and the configuration registers;
// the row state also returns to its reset value on every row-start word.
module teletext_row_attribute_decoder_top
	import tra_pkg::*;
(
	input  logic      clk,
	input  logic      arst_n,
	tra_in_if.sink    in_ch,
	tra_out_if.source out_ch,
	tra_cfg_if.sink   cfg_ch
);

	logic       in_valid_s1;
	logic [6:0] code_s1;
	logic       row_start_s1;
	logic [2:0] subset_s1;
	logic       out_valid_s2;
	cell_res_t  res_s2;
	row_state_t row_q;
	cell_cnt_t  cnt_q;
	cfg_regs_t  cfg_q;

	logic       advance;
	logic       fire;
	row_state_t row_base;
	row_state_t row_next;
	cell_cnt_t  cnt_base;
	cell_cnt_t  cnt_next;
	logic [6:0] code_eff;
	cell_res_t  res_next;

	// Configuration writes; the channel never stalls.
	assign cfg_ch.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= CFG_RESET;
		end else if (cfg_ch.valid) begin
			case (cfg_ch.index)
				REG_DEFAULT_SET: cfg_q.default_set <= cfg_ch.data;
				REG_HAS_SECOND: cfg_q.has_second <= cfg_ch.data[0];
				REG_SECOND_SET: cfg_q.second_set <= cfg_ch.data;
				REG_SECOND_SUBSET: cfg_q.second_subset <= cfg_ch.data[2:0];
				default: ;
			endcase
		end
	end

	// Handshake: stage one moves on when the output stage is empty or taken.
	assign advance = !out_valid_s2 || out_ch.ready;
	assign fire = in_valid_s1 && advance;
	assign in_ch.ready = !in_valid_s1 || advance;

	// Row state as seen by this cell, with the row-start reset applied first.
	always_comb begin
		row_base = row_start_s1 ? ROW_RESET : row_q;
		cnt_base = row_start_s1 ? '0 : cnt_q;
		code_eff = (cnt_base >= cell_cnt_t'(ROW_CELLS)) ? CODE_SPACE : code_s1;
		cnt_next = (cnt_base < cell_cnt_t'(ROW_CELLS)) ? cnt_base + 1'b1 : cnt_base;
	end

	tra_decode u_decode (
		.st         (row_base),
		.code       (code_eff),
		.cfg        (cfg_q),
		.page_subset(subset_s1),
		.nxt        (row_next),
		.res        (res_next)
	);

	// Control registers: stage valids, row state and cell counter.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_valid_s1 <= 1'b0;
			out_valid_s2 <= 1'b0;
			row_q <= ROW_RESET;
			cnt_q <= '0;
		end else begin
			if (in_ch.ready) in_valid_s1 <= in_ch.valid;
			if (advance) out_valid_s2 <= in_valid_s1;
			if (fire) begin
				row_q <= row_next;
				cnt_q <= cnt_next;
			end
		end
	end

	// Payload registers.
	always_ff @(posedge clk) begin
		if (in_ch.ready && in_ch.valid) begin
			code_s1 <= in_ch.code_byte[6:0];
			row_start_s1 <= in_ch.row_start;
			subset_s1 <= in_ch.page_option_subset;
		end
		if (fire) res_s2 <= res_next;
	end

	// Output word.
	assign out_ch.valid = out_valid_s2;
	assign out_ch.character = res_s2.character;
	assign out_ch.foreground = res_s2.foreground;
	assign out_ch.background = res_s2.background;
	assign out_ch.mosaic = res_s2.mosaic;
	assign out_ch.separated = res_s2.separated;
	assign out_ch.flashing = res_s2.flashing;
	assign out_ch.concealed = res_s2.concealed;
	assign out_ch.in_box = res_s2.in_box;
	assign out_ch.tall = res_s2.tall;
	assign out_ch.held_mark = res_s2.held_mark;
	assign out_ch.char_set = res_s2.char_set;
	assign out_ch.option_subset = res_s2.option_subset;

`ifndef ASSERT_OFF
	// Double height is only reported on column 0 control cells, which show a space.
	a_tall_space: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_s2 && res_s2.tall |-> res_s2.character == CODE_SPACE)
		else $error("tall cell with a non-space character");

	// The cell counter saturates at the row length.
	a_cnt_range: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= cell_cnt_t'(ROW_CELLS))
		else $error("cell counter beyond the row length");

	// Without a second set every cell uses the default set.
	a_default_set: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_s2 && !cfg_q.has_second |-> res_s2.char_set == cfg_q.default_set)
		else $error("second set used while none is configured");

	// A word in stage one that cannot move on stays put.
	a_s1_hold: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid_s1 && !advance |=> in_valid_s1 && $stable(code_s1))
		else $error("stage one lost or changed a stalled word");
`endif

endmodule
